// ===== rtl/clbs_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and helpers for the character display bus sequencer.
// Used by clbs_step and char_lcd_bus_sequencer_core; depends on nothing else.
package clbs_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int CFG_W       = 16;
    localparam int SUM_W       = ((CFG_W > COUNT_WIDTH) ? CFG_W : COUNT_WIDTH) + 1;
    localparam int IDX_W       = 3;

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};
    localparam logic [SUM_W-1:0]       WAKE_LONG  = SUM_W'(5000);
    localparam logic [SUM_W-1:0]       WAKE_SHORT = SUM_W'(100);
    localparam int                     BUSY_BIT   = 7;

    localparam logic [2:0] WAKE_IDLE   = 3'd0;
    localparam logic [2:0] WAKE_FIRST  = 3'd1;
    localparam logic [2:0] WAKE_SECOND = 3'd2;
    localparam logic [2:0] WAKE_THIRD  = 3'd3;
    localparam logic [2:0] WAKE_PULSES = 3'd4;

    localparam logic [7:0] WAKE_BYTE_8BIT = 8'h30;
    localparam logic [7:0] WAKE_BYTE_4BIT = 8'h20;

    // Request codes.
    localparam logic [1:0] REQ_TICK = 2'd0;
    localparam logic [1:0] REQ_CMD  = 2'd1;
    localparam logic [1:0] REQ_DATA = 2'd2;
    localparam logic [1:0] REQ_WAKE = 2'd3;

    // Configuration register indexes.
    localparam logic [IDX_W-1:0] CFG_SETUP      = 3'd0;
    localparam logic [IDX_W-1:0] CFG_EN_HOLD    = 3'd1;
    localparam logic [IDX_W-1:0] CFG_DATA_HOLD  = 3'd2;
    localparam logic [IDX_W-1:0] CFG_BUSY_INTV  = 3'd3;
    localparam logic [IDX_W-1:0] CFG_BUSY_SHORT = 3'd4;
    localparam logic [IDX_W-1:0] CFG_FOUR_BIT   = 3'd5;
    localparam logic [IDX_W-1:0] CFG_WRITE_ONLY = 3'd6;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_SET,
        PH_EN,
        PH_LOW,
        PH_RD_SET,
        PH_RD_EN,
        PH_RD_SAMPLE,
        PH_RD_FALL,
        PH_RD_EN2,
        PH_RD_FALL2,
        PH_CLOSE,
        PH_CLOSE_WO
    } phase_t;

    typedef struct packed {
        logic       rw;
        logic       rs;
        logic       en;
        logic [7:0] data;
    } pins_t;

    typedef struct packed {
        logic [CFG_W-1:0] setup_ticks;
        logic [CFG_W-1:0] enable_hold_ticks;
        logic [CFG_W-1:0] data_hold_ticks;
        logic [CFG_W-1:0] busy_interval_ticks;
        logic [CFG_W-1:0] busy_short_ticks;
        logic             four_bit_mode;
        logic             write_only;
    } cfg_t;

    typedef struct packed {
        phase_t                 phase;
        logic [COUNT_WIDTH-1:0] wait_count;
        logic [7:0]             held_byte;
        logic                   held_is_data;
        logic                   low_nibble_pending;
        logic [2:0]             wake_step;
        logic                   busy_sample;
        pins_t                  pins;
    } seq_state_t;

    typedef struct packed {
        logic       pin_rw;
        logic       pin_rs;
        logic       pin_en;
        logic [7:0] bus_out;
        logic       ready_res;
        logic       done_res;
        logic       error;
    } res_t;

    function automatic logic [SUM_W-1:0] widen(input logic [CFG_W-1:0] v);
        return SUM_W'(v);
    endfunction

    function automatic logic [COUNT_WIDTH-1:0] sat(input logic [SUM_W-1:0] v);
        logic [COUNT_WIDTH-1:0] r;
        if (v > SUM_W'(CNT_MAX))
        begin
            r = CNT_MAX;
        end
        else
        begin
            r = v[COUNT_WIDTH-1:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/clbs_step.sv =====
`timescale 1ns / 1ps
// One tick of the bus sequencer: next state and result item from the current
// state, the live configuration and one input item. Depends on clbs_pkg.
module clbs_step (
    input  clbs_pkg::seq_state_t cur,
    input  clbs_pkg::cfg_t       cfg,
    input  logic [1:0]           req_type,
    input  logic [7:0]           req_byte,
    input  logic [7:0]           bus_in,
    input  logic                 bus_fault,
    output clbs_pkg::seq_state_t nxt,
    output clbs_pkg::res_t       res
);

    clbs_pkg::seq_state_t st;
    logic eval_c;
    logic access_c;
    logic closing_c;

    // A new request is taken only when idle; it starts with no wait so the
    // first bus access lands on the same tick.
    always_comb
    begin
        st = cur;
        if (cur.phase == clbs_pkg::PH_IDLE && req_type != clbs_pkg::REQ_TICK)
        begin
            st.held_is_data = (req_type == clbs_pkg::REQ_DATA);
            if (req_type == clbs_pkg::REQ_WAKE)
            begin
                st.held_byte          = clbs_pkg::WAKE_BYTE_8BIT;
                st.wake_step          = clbs_pkg::WAKE_FIRST;
                st.low_nibble_pending = 1'b0;
            end
            else
            begin
                st.held_byte          = req_byte;
                st.wake_step          = clbs_pkg::WAKE_IDLE;
                st.low_nibble_pending = cfg.four_bit_mode;
            end
            st.wait_count = '0;
            st.phase      = clbs_pkg::PH_SET;
        end
    end

    // Next state.
    always_comb
    begin
        logic [clbs_pkg::SUM_W-1:0] w;
        clbs_pkg::phase_t           nph;
        nxt       = st;
        eval_c    = 1'b0;
        access_c  = 1'b0;
        closing_c = 1'b0;
        w         = '0;
        nph       = clbs_pkg::PH_IDLE;
        if (st.phase != clbs_pkg::PH_IDLE)
        begin
            if (st.wait_count != '0)
            begin
                nxt.wait_count = st.wait_count - 1'b1;
            end
            else
            begin
                eval_c   = 1'b1;
                access_c = 1'b1;
                unique case (st.phase) inside
                    clbs_pkg::PH_SET:
                    begin
                        nxt.pins = '{1'b0, st.held_is_data, 1'b0, st.held_byte};
                        w        = clbs_pkg::widen(cfg.setup_ticks);
                        nph      = clbs_pkg::PH_EN;
                    end
                    clbs_pkg::PH_EN:
                    begin
                        nxt.pins = '{1'b0, st.held_is_data, 1'b1, st.held_byte};
                        w        = clbs_pkg::widen(cfg.enable_hold_ticks);
                        nph      = clbs_pkg::PH_LOW;
                    end
                    clbs_pkg::PH_LOW:
                    begin
                        nxt.pins = '{1'b0, st.held_is_data, 1'b0, st.held_byte};
                        nph      = clbs_pkg::PH_SET;
                        if (st.wake_step == clbs_pkg::WAKE_FIRST)
                        begin
                            w             = clbs_pkg::WAKE_LONG;
                            nxt.wake_step = clbs_pkg::WAKE_SECOND;
                        end
                        else if (st.wake_step == clbs_pkg::WAKE_SECOND)
                        begin
                            // The third pulse repeats enable without a new setup.
                            w             = clbs_pkg::WAKE_SHORT;
                            nxt.wake_step = clbs_pkg::WAKE_THIRD;
                            nph           = clbs_pkg::PH_EN;
                        end
                        else if (st.wake_step == clbs_pkg::WAKE_THIRD)
                        begin
                            w             = clbs_pkg::widen(cfg.data_hold_ticks);
                            nxt.wake_step = clbs_pkg::WAKE_PULSES;
                            nxt.held_byte = clbs_pkg::WAKE_BYTE_4BIT;
                        end
                        else if (st.wake_step != clbs_pkg::WAKE_IDLE)
                        begin
                            w = clbs_pkg::widen(cfg.data_hold_ticks) + clbs_pkg::WAKE_SHORT;
                            nxt.wake_step          = clbs_pkg::WAKE_IDLE;
                            nxt.low_nibble_pending = cfg.four_bit_mode;
                        end
                        else if (st.low_nibble_pending)
                        begin
                            nxt.low_nibble_pending = 1'b0;
                            nxt.held_byte          = {st.held_byte[3:0], 4'b0000};
                            w = clbs_pkg::widen(cfg.data_hold_ticks);
                        end
                        else if (cfg.write_only)
                        begin
                            w = clbs_pkg::widen(cfg.data_hold_ticks)
                                + clbs_pkg::widen(cfg.busy_short_ticks);
                            nph = clbs_pkg::PH_CLOSE_WO;
                        end
                        else
                        begin
                            w   = clbs_pkg::widen(cfg.data_hold_ticks);
                            nph = clbs_pkg::PH_RD_SET;
                        end
                    end
                    clbs_pkg::PH_RD_SET:
                    begin
                        nxt.pins = '{1'b1, 1'b0, 1'b0, 8'h00};
                        w = clbs_pkg::widen(cfg.setup_ticks)
                            + clbs_pkg::widen(cfg.busy_interval_ticks);
                        nph = clbs_pkg::PH_RD_EN;
                    end
                    clbs_pkg::PH_RD_EN, clbs_pkg::PH_RD_EN2:
                    begin
                        nxt.pins = '{1'b1, 1'b0, 1'b1, 8'h00};
                        w        = clbs_pkg::widen(cfg.enable_hold_ticks);
                        nph      = (st.phase == clbs_pkg::PH_RD_EN) ?
                                   clbs_pkg::PH_RD_SAMPLE : clbs_pkg::PH_RD_FALL2;
                    end
                    clbs_pkg::PH_RD_SAMPLE:
                    begin
                        nxt.pins        = '{1'b1, 1'b0, 1'b1, 8'h00};
                        nxt.busy_sample = bus_in[clbs_pkg::BUSY_BIT];
                        nph             = clbs_pkg::PH_RD_FALL;
                    end
                    clbs_pkg::PH_RD_FALL, clbs_pkg::PH_RD_FALL2:
                    begin
                        nxt.pins = '{1'b1, 1'b0, 1'b0, 8'h00};
                        if (st.phase == clbs_pkg::PH_RD_FALL && cfg.four_bit_mode)
                        begin
                            w   = clbs_pkg::widen(cfg.data_hold_ticks);
                            nph = clbs_pkg::PH_RD_EN2;
                        end
                        else if (st.busy_sample)
                        begin
                            w   = clbs_pkg::widen(cfg.busy_interval_ticks);
                            nph = clbs_pkg::PH_RD_EN;
                        end
                        else
                        begin
                            nph = clbs_pkg::PH_CLOSE;
                        end
                    end
                    clbs_pkg::PH_CLOSE:
                    begin
                        nxt.pins = '0;
                    end
                    default:
                    begin
                        // Write-only closing tick: no bus access, so no fault check.
                        nxt.pins = '0;
                        access_c = 1'b0;
                    end
                endcase

                closing_c = (st.phase == clbs_pkg::PH_CLOSE)
                            || (st.phase == clbs_pkg::PH_CLOSE_WO);
                if ((access_c && bus_fault) || closing_c || nph == clbs_pkg::PH_IDLE)
                begin
                    nxt.phase              = clbs_pkg::PH_IDLE;
                    nxt.wait_count         = '0;
                    nxt.wake_step          = clbs_pkg::WAKE_IDLE;
                    nxt.low_nibble_pending = 1'b0;
                    nxt.pins               = '0;
                end
                else
                begin
                    nxt.phase      = nph;
                    nxt.wait_count = clbs_pkg::sat(w);
                end
            end
        end
    end

    // Result item.
    always_comb
    begin
        res.pin_rw    = nxt.pins.rw;
        res.pin_rs    = nxt.pins.rs;
        res.pin_en    = nxt.pins.en;
        res.bus_out   = nxt.pins.data;
        res.ready_res = (nxt.phase == clbs_pkg::PH_IDLE);
        res.error     = eval_c && access_c && bus_fault;
        res.done_res  = eval_c && closing_c && !(access_c && bus_fault);
    end

endmodule

// ===== rtl/char_lcd_bus_sequencer_core.sv =====
`timescale 1ns / 1ps
// Top level of the character display bus sequencer: configuration registers,
// sequencer state, output register and skid stage. Depends on clbs_pkg, clbs_step.
//
// Usage: each input item is one timing tick (nominally one microsecond) and
// carries an optional request (command write, data write, four-bit wake-up)
// together with the bus value read and a fault flag for that tick. Every input
// item yields exactly one result item with the pin levels (RW, RS, EN, data),
// ready, done and error for that tick.
// Both channels use valid/stall; an item moves when valid is high and stall is
// low. The whole tick is evaluated between the state registers and the result
// register, so a result is registered as its item is accepted and one
// item is taken every cycle while the receiver keeps up. When the receiver
// stalls, one further item is held in a skid stage; in_stall then rises and
// stays high until the skid entry drains.
// Configuration must be written through cfg_wr_en/cfg_index/cfg_data only while
// idle; the block does not enforce this. Reset clears the sequencer to idle with
// all pins low, loads the register defaults and empties the output stages.
module char_lcd_bus_sequencer_core (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [clbs_pkg::IDX_W-1:0] cfg_index,
    input  logic [clbs_pkg::CFG_W-1:0] cfg_data,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [1:0]                 req_type,
    input  logic [7:0]                 req_byte,
    input  logic [7:0]                 bus_in,
    input  logic                       bus_fault,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic                       pin_rw,
    output logic                       pin_rs,
    output logic                       pin_en,
    output logic [7:0]                 bus_out,
    output logic                       ready_res,
    output logic                       done_res,
    output logic                       error
);

    clbs_pkg::cfg_t       cfg_reg;
    clbs_pkg::seq_state_t state_reg;
    clbs_pkg::seq_state_t state_next;
    clbs_pkg::res_t       step_res;
    clbs_pkg::res_t       out_reg;
    clbs_pkg::res_t       skid_reg;
    logic                 out_valid_reg;
    logic                 skid_valid_reg;
    logic                 in_accept;
    logic                 out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.setup_ticks         <= 16'd1;
            cfg_reg.enable_hold_ticks   <= 16'd1;
            cfg_reg.data_hold_ticks     <= 16'd1;
            cfg_reg.busy_interval_ticks <= 16'd1;
            cfg_reg.busy_short_ticks    <= 16'd40;
            cfg_reg.four_bit_mode       <= 1'b1;
            cfg_reg.write_only          <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                clbs_pkg::CFG_SETUP:      cfg_reg.setup_ticks         <= cfg_data;
                clbs_pkg::CFG_EN_HOLD:    cfg_reg.enable_hold_ticks   <= cfg_data;
                clbs_pkg::CFG_DATA_HOLD:  cfg_reg.data_hold_ticks     <= cfg_data;
                clbs_pkg::CFG_BUSY_INTV:  cfg_reg.busy_interval_ticks <= cfg_data;
                clbs_pkg::CFG_BUSY_SHORT: cfg_reg.busy_short_ticks    <= cfg_data;
                clbs_pkg::CFG_FOUR_BIT:   cfg_reg.four_bit_mode       <= cfg_data[0];
                clbs_pkg::CFG_WRITE_ONLY: cfg_reg.write_only          <= cfg_data[0];
                default:                  ;
            endcase
        end
    end

    clbs_step u_step (
        .cur       (state_reg),
        .cfg       (cfg_reg),
        .req_type  (req_type),
        .req_byte  (req_byte),
        .bus_in    (bus_in),
        .bus_fault (bus_fault),
        .nxt       (state_next),
        .res       (step_res)
    );

    assign in_stall  = skid_valid_reg;
    assign in_accept = in_valid && !skid_valid_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase              <= clbs_pkg::PH_IDLE;
            state_reg.wait_count         <= '0;
            state_reg.held_byte          <= '0;
            state_reg.held_is_data       <= 1'b0;
            state_reg.low_nibble_pending <= 1'b0;
            state_reg.wake_step          <= clbs_pkg::WAKE_IDLE;
            state_reg.busy_sample        <= 1'b0;
            state_reg.pins               <= '0;
        end
        else if (in_accept)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg  <= skid_valid_reg || in_accept;
            skid_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            out_reg <= skid_valid_reg ? skid_reg : step_res;
        end
        else if (in_accept)
        begin
            skid_reg <= step_res;
        end
    end

    assign out_valid = out_valid_reg;
    assign pin_rw    = out_reg.pin_rw;
    assign pin_rs    = out_reg.pin_rs;
    assign pin_en    = out_reg.pin_en;
    assign bus_out   = out_reg.bus_out;
    assign ready_res = out_reg.ready_res;
    assign done_res  = out_reg.done_res;
    assign error     = out_reg.error;

    // The skid entry is only ever filled behind a held output item.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid while output register empty");

    // An item taken while the output is held must land in the skid stage.
    a_stall_to_skid: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall && in_accept) |=> skid_valid_reg)
        else $error("item accepted under stall was not kept");

    // A finished or aborted request leaves the sequencer idle with enable low.
    a_end_is_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (done_res || error)) |-> (ready_res && !pin_en))
        else $error("request end without return to idle");

    // Done and error are never raised by the same tick.
    a_done_xor_err: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(done_res && error))
        else $error("done and error raised together");

endmodule

// ===== dv/tb_char_lcd_bus_sequencer_core.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for char_lcd_bus_sequencer_core: drives timing ticks with requests,
// predicts every result item and compares pins and status. Depends on clbs_pkg and the RTL.
module tb_char_lcd_bus_sequencer_core;
    import clbs_pkg::*;

    localparam int                 CYCLE_LIMIT = 400000;
    localparam int                 MAX_REPORTS = 10;
    localparam logic [IDX_W-1:0]   CFG_UNUSED  = 3'd7;

    typedef struct packed {
        logic [1:0] req;
        logic [7:0] data_v;
        logic [7:0] bus_v;
        logic       fault;
    } lcd_tick_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_wr_en = 1'b0;
    logic [IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;
    logic             in_valid = 1'b0;
    logic             in_stall;
    logic [1:0]       req_type = REQ_TICK;
    logic [7:0]       req_byte = 8'h00;
    logic [7:0]       bus_in = 8'h00;
    logic             bus_fault = 1'b0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    logic             pin_rw;
    logic             pin_rs;
    logic             pin_en;
    logic [7:0]       bus_out;
    logic             ready_res;
    logic             done_res;
    logic             error;

    char_lcd_bus_sequencer_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .req_type  (req_type),
        .req_byte  (req_byte),
        .bus_in    (bus_in),
        .bus_fault (bus_fault),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .pin_rw    (pin_rw),
        .pin_rs    (pin_rs),
        .pin_en    (pin_en),
        .bus_out   (bus_out),
        .ready_res (ready_res),
        .done_res  (done_res),
        .error     (error)
    );

    always #5 clk = ~clk;

    cfg_t        cfg;
    seq_state_t  pred_state;
    seq_state_t  gen_state;
    lcd_tick_t   pending_ticks[$];
    res_t        pin_expq[$];
    lcd_tick_t   drv_item;
    int          burst_left = 0;
    int          gap_left = 0;
    int          stall_mode = 0;
    int          mode_left = 0;
    int          hold_cnt = 0;
    int          cyc = 0;
    int          n_fail = 0;

    function automatic pins_t pin_lv(input logic rw, input logic rs, input logic en,
                                     input logic [7:0] d);
        pin_lv = {rw, rs, en, d};
    endfunction

    // Advances the sequencer by one tick and returns the pin and status levels of that tick.
    function automatic res_t lcd_tick(inout seq_state_t s, input cfg_t c, input lcd_tick_t it);
        res_t        r;
        logic        acc;
        logic        finish;
        logic        done;
        logic        err;
        logic [SUM_W-1:0] w;
        phase_t      nxt;
        done = 1'b0;
        err = 1'b0;
        if (s.phase == PH_IDLE && it.req != REQ_TICK)
        begin
            s.held_is_data = (it.req == REQ_DATA);
            if (it.req == REQ_WAKE)
            begin
                s.held_byte = WAKE_BYTE_8BIT;
                s.wake_step = WAKE_FIRST;
                s.low_nibble_pending = 1'b0;
            end
            else
            begin
                s.held_byte = it.data_v;
                s.wake_step = WAKE_IDLE;
                s.low_nibble_pending = c.four_bit_mode;
            end
            s.wait_count = '0;
            s.phase = PH_SET;
        end
        if (s.phase != PH_IDLE)
        begin
            if (s.wait_count != '0)
            begin
                s.wait_count = s.wait_count - 1'b1;
            end
            else
            begin
                acc = 1'b1;
                w = '0;
                nxt = PH_IDLE;
                case (s.phase)
                    PH_SET:
                    begin
                        s.pins = pin_lv(1'b0, s.held_is_data, 1'b0, s.held_byte);
                        w = SUM_W'(c.setup_ticks);
                        nxt = PH_EN;
                    end
                    PH_EN:
                    begin
                        s.pins = pin_lv(1'b0, s.held_is_data, 1'b1, s.held_byte);
                        w = SUM_W'(c.enable_hold_ticks);
                        nxt = PH_LOW;
                    end
                    PH_LOW:
                    begin
                        s.pins = pin_lv(1'b0, s.held_is_data, 1'b0, s.held_byte);
                        nxt = PH_SET;
                        if (s.wake_step == WAKE_FIRST)
                        begin
                            w = WAKE_LONG;
                            s.wake_step = WAKE_SECOND;
                        end
                        else if (s.wake_step == WAKE_SECOND)
                        begin
                            // The third wake pulse skips the setup step.
                            w = WAKE_SHORT;
                            s.wake_step = WAKE_THIRD;
                            nxt = PH_EN;
                        end
                        else if (s.wake_step == WAKE_THIRD)
                        begin
                            w = SUM_W'(c.data_hold_ticks);
                            s.wake_step = WAKE_PULSES;
                            s.held_byte = WAKE_BYTE_4BIT;
                        end
                        else if (s.wake_step != WAKE_IDLE)
                        begin
                            w = SUM_W'(c.data_hold_ticks) + WAKE_SHORT;
                            s.wake_step = WAKE_IDLE;
                            s.low_nibble_pending = c.four_bit_mode;
                        end
                        else if (s.low_nibble_pending)
                        begin
                            s.low_nibble_pending = 1'b0;
                            s.held_byte = {s.held_byte[3:0], 4'h0};
                            w = SUM_W'(c.data_hold_ticks);
                        end
                        else if (c.write_only)
                        begin
                            w = SUM_W'(c.data_hold_ticks) + SUM_W'(c.busy_short_ticks);
                            nxt = PH_CLOSE_WO;
                        end
                        else
                        begin
                            w = SUM_W'(c.data_hold_ticks);
                            nxt = PH_RD_SET;
                        end
                    end
                    PH_RD_SET:
                    begin
                        s.pins = pin_lv(1'b1, 1'b0, 1'b0, 8'h00);
                        w = SUM_W'(c.setup_ticks) + SUM_W'(c.busy_interval_ticks);
                        nxt = PH_RD_EN;
                    end
                    PH_RD_EN:
                    begin
                        s.pins = pin_lv(1'b1, 1'b0, 1'b1, 8'h00);
                        w = SUM_W'(c.enable_hold_ticks);
                        nxt = PH_RD_SAMPLE;
                    end
                    PH_RD_SAMPLE:
                    begin
                        s.pins = pin_lv(1'b1, 1'b0, 1'b1, 8'h00);
                        s.busy_sample = it.bus_v[BUSY_BIT];
                        nxt = PH_RD_FALL;
                    end
                    PH_RD_FALL, PH_RD_FALL2:
                    begin
                        s.pins = pin_lv(1'b1, 1'b0, 1'b0, 8'h00);
                        if (s.phase == PH_RD_FALL && c.four_bit_mode)
                        begin
                            w = SUM_W'(c.data_hold_ticks);
                            nxt = PH_RD_EN2;
                        end
                        else if (s.busy_sample)
                        begin
                            w = SUM_W'(c.busy_interval_ticks);
                            nxt = PH_RD_EN;
                        end
                        else
                        begin
                            nxt = PH_CLOSE;
                        end
                    end
                    PH_RD_EN2:
                    begin
                        s.pins = pin_lv(1'b1, 1'b0, 1'b1, 8'h00);
                        w = SUM_W'(c.enable_hold_ticks);
                        nxt = PH_RD_FALL2;
                    end
                    PH_CLOSE:
                    begin
                        s.pins = '0;
                    end
                    default:
                    begin
                        // The write-only closing tick is not a bus access.
                        s.pins = '0;
                        acc = 1'b0;
                    end
                endcase
                finish = 1'b0;
                if (acc && it.fault)
                begin
                    err = 1'b1;
                    finish = 1'b1;
                end
                else if (s.phase == PH_CLOSE || s.phase == PH_CLOSE_WO || nxt == PH_IDLE)
                begin
                    done = (s.phase == PH_CLOSE || s.phase == PH_CLOSE_WO);
                    finish = 1'b1;
                end
                else
                begin
                    s.phase = nxt;
                    s.wait_count = (w > SUM_W'(CNT_MAX)) ? CNT_MAX : w[COUNT_WIDTH-1:0];
                end
                if (finish)
                begin
                    s.phase = PH_IDLE;
                    s.wait_count = '0;
                    s.wake_step = WAKE_IDLE;
                    s.low_nibble_pending = 1'b0;
                    s.pins = '0;
                end
            end
        end
        r.pin_rw = s.pins.rw;
        r.pin_rs = s.pins.rs;
        r.pin_en = s.pins.en;
        r.bus_out = s.pins.data;
        r.ready_res = (s.phase == PH_IDLE);
        r.done_res = done;
        r.error = err;
        return r;
    endfunction

    function automatic lcd_tick_t mk_item(input logic [1:0] req, input logic [7:0] d,
                                          input logic [7:0] b, input logic f);
        mk_item = {req, d, b, f};
    endfunction

    function automatic lcd_tick_t rand_item(input int busy_pct, input int fault_pct);
        lcd_tick_t it;
        it.req = 2'($urandom_range(0, 3));
        it.data_v = 8'($urandom_range(0, 255));
        it.bus_v = 8'($urandom_range(0, 255));
        it.bus_v[BUSY_BIT] = ($urandom_range(0, 99) < busy_pct);
        it.fault = ($urandom_range(0, 99) < fault_pct);
        return it;
    endfunction

    // The generator runs its own copy of the sequencer so it knows when a request would start.
    task automatic push_item(input lcd_tick_t it);
        pending_ticks.push_back(it);
        void'(lcd_tick(gen_state, cfg, it));
    endtask

    task automatic run_to_idle(input int busy_pct);
        int k;
        k = 0;
        while (gen_state.phase != PH_IDLE && k < 20000)
        begin
            push_item(rand_item(busy_pct, 0));
            k++;
        end
    endtask

    task automatic gen_random(input int n, input int busy_pct);
        lcd_tick_t it;
        int        r;
        for (int i = 0; i < n; i++)
        begin
            it = rand_item(busy_pct, 2);
            if (gen_state.phase == PH_IDLE)
            begin
                r = $urandom_range(0, 9);
                it.req = (r < 2) ? REQ_TICK : ((r < 6) ? REQ_CMD : REQ_DATA);
            end
            push_item(it);
        end
    endtask

    task automatic wait_drained();
        while (pending_ticks.size() != 0 || in_valid || pin_expq.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            CFG_SETUP:      cfg.setup_ticks = val;
            CFG_EN_HOLD:    cfg.enable_hold_ticks = val;
            CFG_DATA_HOLD:  cfg.data_hold_ticks = val;
            CFG_BUSY_INTV:  cfg.busy_interval_ticks = val;
            CFG_BUSY_SHORT: cfg.busy_short_ticks = val;
            CFG_FOUR_BIT:   cfg.four_bit_mode = val[0];
            CFG_WRITE_ONLY: cfg.write_only = val[0];
            default:        ;
        endcase
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_regs(input logic [CFG_W-1:0] su, input logic [CFG_W-1:0] eh,
                            input logic [CFG_W-1:0] dh, input logic [CFG_W-1:0] bi,
                            input logic [CFG_W-1:0] bs, input logic [CFG_W-1:0] fb,
                            input logic [CFG_W-1:0] wo);
        write_reg(CFG_SETUP, su);
        write_reg(CFG_EN_HOLD, eh);
        write_reg(CFG_DATA_HOLD, dh);
        write_reg(CFG_BUSY_INTV, bi);
        write_reg(CFG_BUSY_SHORT, bs);
        write_reg(CFG_FOUR_BIT, fb);
        write_reg(CFG_WRITE_ONLY, wo);
    endtask

    function automatic logic [CFG_W-1:0] small_ticks();
        return CFG_W'($urandom_range(0, 3));
    endfunction

    // Sender: bursts of items with random gaps; a stalled item stays on the port unchanged.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                pin_expq.push_back(lcd_tick(pred_state, cfg, drv_item));
            end
            if (in_valid && in_stall)
            begin
                burst_left = burst_left;
            end
            else if (gap_left != 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (pending_ticks.size() != 0)
            begin
                drv_item = pending_ticks.pop_front();
                in_valid <= 1'b1;
                req_type <= drv_item.req;
                req_byte <= drv_item.data_v;
                bus_in <= drv_item.bus_v;
                bus_fault <= drv_item.fault;
                if (burst_left != 0)
                begin
                    burst_left--;
                end
                else
                begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off so that the skid stage fills and the input stalls.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            hold_cnt <= 0;
        end
        else if (hold_cnt != 0)
        begin
            hold_cnt <= hold_cnt - 1;
        end
        else if (cyc == 1500 || cyc == 12000)
        begin
            hold_cnt <= 120;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 300);
            end
            else
            begin
                mode_left--;
            end
            case (stall_mode)
                0:       out_stall <= (hold_cnt != 0);
                1:       out_stall <= (hold_cnt != 0) || ($urandom_range(0, 3) == 0);
                2:       out_stall <= (hold_cnt != 0) || ($urandom_range(0, 9) < 6);
                default: out_stall <= (hold_cnt != 0) || !out_stall;
            endcase
        end
    end

    always @(posedge clk)
    begin
        res_t act;
        res_t exp_r;
        if (rst_n && out_valid && !out_stall)
        begin
            act = {pin_rw, pin_rs, pin_en, bus_out, ready_res, done_res, error};
            if (pin_expq.size() == 0)
            begin
                n_fail++;
                if (n_fail <= MAX_REPORTS)
                begin
                    $display("%0t: result item with nothing expected: %p", $time, act);
                end
            end
            else
            begin
                exp_r = pin_expq.pop_front();
                if (act.pin_rw !== exp_r.pin_rw || act.pin_rs !== exp_r.pin_rs
                    || act.pin_en !== exp_r.pin_en || act.bus_out !== exp_r.bus_out
                    || act.ready_res !== exp_r.ready_res || act.done_res !== exp_r.done_res
                    || act.error !== exp_r.error)
                begin
                    n_fail++;
                    if (n_fail <= MAX_REPORTS)
                    begin
                        // Fields in order: rw, rs, en, bus, ready, done, error.
                        $display("%0t: mismatch exp %b %b %b %h %b %b %b got %b %b %b %h %b %b %b",
                                 $time, exp_r.pin_rw, exp_r.pin_rs, exp_r.pin_en,
                                 exp_r.bus_out, exp_r.ready_res, exp_r.done_res, exp_r.error,
                                 act.pin_rw, act.pin_rs, act.pin_en, act.bus_out,
                                 act.ready_res, act.done_res, act.error);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cyc <= cyc + 1;
        if (cyc > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        pred_state = '0;
        gen_state = '0;
        cfg.setup_ticks = 16'd1;
        cfg.enable_hold_ticks = 16'd1;
        cfg.data_hold_ticks = 16'd1;
        cfg.busy_interval_ticks = 16'd1;
        cfg.busy_short_ticks = 16'd40;
        cfg.four_bit_mode = 1'b1;
        cfg.write_only = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Reset defaults: a fault while idle is ignored, a fault on the first access
        // aborts, then a full four-bit data write with busy polling and ignored requests.
        push_item(mk_item(REQ_TICK, 8'h00, 8'h00, 1'b1));
        push_item(mk_item(REQ_CMD, 8'hFF, 8'hFF, 1'b1));
        push_item(mk_item(REQ_DATA, 8'h00, 8'h7F, 1'b0));
        run_to_idle(0);
        wait_drained();

        // All timings zero, eight-bit polling; upper data bits of a flag write are dropped.
        set_regs(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'h0000, 16'hFFFE);
        gen_random(350, 50);
        wait_drained();

        set_regs(small_ticks(), small_ticks(), small_ticks(), small_ticks(), small_ticks(),
                 16'hFFFF, 16'h0001);
        gen_random(350, 50);
        wait_drained();

        set_regs(small_ticks(), small_ticks(), small_ticks(), small_ticks(), small_ticks(),
                 16'h0001, 16'h0000);
        gen_random(400, 60);
        wait_drained();

        write_reg(CFG_UNUSED, 16'hFFFF);
        set_regs(small_ticks(), small_ticks(), small_ticks(), small_ticks(), small_ticks(),
                 16'h0000, 16'h0000);
        gen_random(350, 40);
        wait_drained();

        // Complete four-bit wake-up sequence followed by its closing command write.
        set_regs(16'd1, 16'd1, 16'd2, 16'd1, 16'd3, 16'h0001, 16'h0000);
        run_to_idle(30);
        push_item(mk_item(REQ_WAKE, 8'h00, 8'h00, 1'b0));
        wait_drained();
        run_to_idle(30);
        wait_drained();

        // Largest counts: the post-transfer wait saturates, and faults during it are ignored.
        set_regs(16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0001);
        run_to_idle(0);
        push_item(mk_item(REQ_CMD, 8'h5A, 8'h00, 1'b0));
        push_item(mk_item(REQ_TICK, 8'h00, 8'h00, 1'b0));
        push_item(mk_item(REQ_TICK, 8'h00, 8'h00, 1'b0));
        for (int i = 0; i < 40; i++)
        begin
            push_item(rand_item(50, 50));
        end
        wait_drained();
        repeat (10) @(posedge clk);

        if (n_fail == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
